// ===== rtl/krn_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// krn_pkg
// Shared widths and record types of the kernel rank normaliser.
// ---------------------------------------------------------------------------
package krn_pkg;

  localparam int VAL_W  = 32;          // sample value, signed Q16.16
  localparam int RANK_W = 6;           // rank of one position
  localparam int FRAC_W = 16;          // threshold fraction, Q0.16
  localparam int DIV_W  = RANK_W + 1;  // divider operands: rank+1 and count+1

  // One queued item, classified by the front end
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    drop;
  } item_t;

  // One result transfer
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [FRAC_W-1:0] frac;
    logic              run_end;
    logic              ovf;
  } result_t;

endpackage : krn_pkg
`default_nettype wire

// ===== rtl/krn_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// krn_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module krn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : krn_ram
`default_nettype wire

// ===== rtl/krn_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// krn_front
// Accepts items, marks those beyond capacity for dropping, and queues them.
// ---------------------------------------------------------------------------
module krn_front
  import krn_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [VAL_W-1:0] in_sample_value,
  input  wire logic                    in_is_final,
  output logic                         q_valid,
  output item_t                        q_item,
  input  wire logic                    q_pop
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       occ_r, occ_nxt;
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  item_t            slot_r [2];
  logic             accept;
  logic             pop;
  item_t            new_item;

  assign busy    = (occ_r == 2'd2);
  assign accept  = start && !busy;
  assign q_valid = (occ_r != 2'd0);
  assign q_item  = slot_r[rp_r];
  assign pop     = q_pop && q_valid;

  always_comb begin
    new_item.value = in_sample_value;
    new_item.last  = in_is_final;
    new_item.drop  = (cnt_r == CNT_W'(MAX_ENTRIES));
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_is_final) begin
        cnt_nxt = '0;
      end else if (!new_item.drop) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    wp_nxt  = accept ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    occ_nxt = occ_r + {1'b0, accept} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      occ_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      occ_r <= occ_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  // Queue storage holds payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r[wp_r] <= new_item;
    end
  end

endmodule : krn_front
`default_nettype wire

// ===== rtl/krn_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// krn_div
// Restoring divider, one quotient bit a cycle: floor(numer * 2^16 / denom).
// ---------------------------------------------------------------------------
module krn_div
  import krn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  numer,
  input  wire logic [DIV_W-1:0]  denom,
  output logic                   done,
  output logic [FRAC_W-1:0]      quot
);

  localparam int STEP_W = $clog2(FRAC_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  den_r, den_nxt;
  logic [FRAC_W-1:0] q_r, q_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // Numerator is below the denominator, so the remainder stays within DIV_W bits
  assign trial = {rem_r, 1'b0};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_W'(FRAC_W - 1);
      rem_nxt  = numer;
      den_nxt  = denom;
      q_nxt    = '0;
    end else if (run_r) begin
      rem_nxt  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      q_nxt    = {q_r[FRAC_W-2:0], ge};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule : krn_div
`default_nettype wire

// ===== rtl/krn_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// krn_back
// Ranks each queued value against the stored ones, then emits the results.
// ---------------------------------------------------------------------------
module krn_back
  import krn_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  item_t     q_item,
  output logic      q_pop,
  output logic      res_valid,
  output result_t   res
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ERD  = 3'd2;
  localparam logic [2:0] S_ELD  = 3'd3;
  localparam logic [2:0] S_EDIV = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [RANK_W-1:0]       rk_r, rk_nxt;
  logic                    last_r, last_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic signed [VAL_W-1:0] v_r, v_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic [RANK_W-1:0]       r_r, r_nxt;
  result_t                 res_r, res_nxt;

  logic                    val_we, val_re;
  logic                    rank_we, rank_re;
  logic [IDX_W-1:0]        val_waddr, rank_waddr, rd_addr;
  logic [VAL_W-1:0]        val_wdata, val_rdata;
  logic [RANK_W-1:0]       rank_wdata, rank_rdata;
  logic                    issue;
  logic                    run_end;
  logic                    div_start, div_done;
  logic [FRAC_W-1:0]       div_quot;

  krn_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .re    (val_re),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  krn_ram #(.WIDTH(RANK_W), .DEPTH(MAX_ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .re    (rank_re),
    .raddr (rd_addr),
    .rdata (rank_rdata)
  );

  krn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (DIV_W'(rank_rdata) + DIV_W'(1)),
    .denom (DIV_W'(fill_r) + DIV_W'(1)),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign issue   = (i_r < fill_r);
  assign run_end = ((k_r + CNT_W'(1)) == fill_r);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    i_nxt       = i_r;
    k_nxt       = k_r;
    rk_nxt      = rk_r;
    last_nxt    = last_r;
    rd_vld_nxt  = 1'b0;
    out_vld_nxt = 1'b0;
    v_nxt       = v_r;
    rd_idx_nxt  = rd_idx_r;
    r_nxt       = r_r;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    val_we      = 1'b0;
    val_re      = 1'b0;
    rank_we     = 1'b0;
    rank_re     = 1'b0;
    val_waddr   = fill_r[IDX_W-1:0];
    val_wdata   = v_r;
    rank_waddr  = fill_r[IDX_W-1:0];
    rank_wdata  = rk_r;
    rd_addr     = i_r[IDX_W-1:0];
    div_start   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          v_nxt    = q_item.value;
          last_nxt = q_item.last;
          i_nxt    = '0;
          k_nxt    = '0;
          rk_nxt   = '0;
          if (q_item.drop) begin
            ovf_nxt = 1'b1;
            if (q_item.last) begin
              state_nxt = S_ERD;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          val_re     = 1'b1;
          rank_re    = 1'b1;
          i_nxt      = i_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = i_r[IDX_W-1:0];
        end
        if (rd_vld_r) begin
          if ($signed(val_rdata) <= v_r) begin
            rk_nxt = rk_r + RANK_W'(1);
          end else begin
            rank_we    = 1'b1;
            rank_waddr = rd_idx_r;
            rank_wdata = rank_rdata + RANK_W'(1);
          end
        end
        // Scan drained: store the value with its final rank
        if (!issue && !rd_vld_r) begin
          val_we    = 1'b1;
          rank_we   = 1'b1;
          fill_nxt  = fill_r + CNT_W'(1);
          state_nxt = last_r ? S_ERD : S_IDLE;
        end
      end
      S_ERD: begin
        rank_re   = 1'b1;
        rd_addr   = k_r[IDX_W-1:0];
        state_nxt = S_ELD;
      end
      S_ELD: begin
        div_start = 1'b1;
        r_nxt     = rank_rdata;
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        if (div_done) begin
          out_vld_nxt     = 1'b1;
          res_nxt.rank    = r_r;
          res_nxt.frac    = div_quot;
          res_nxt.run_end = run_end;
          res_nxt.ovf     = ovf_r;
          if (run_end) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      ovf_r     <= 1'b0;
      i_r       <= '0;
      k_r       <= '0;
      rk_r      <= '0;
      last_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      ovf_r     <= ovf_nxt;
      i_r       <= i_nxt;
      k_r       <= k_nxt;
      rk_r      <= rk_nxt;
      last_r    <= last_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    rd_idx_r <= rd_idx_nxt;
    r_r      <= r_nxt;
    res_r    <= res_nxt;
  end

  assign res_valid = out_vld_r;
  assign res       = res_r;

endmodule : krn_back
`default_nettype wire

// ===== rtl/kernel_rank_normalizer_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kernel_rank_normalizer_unit
// Rank transform of a threshold kernel: stores the values of one run, ranks
// them ascending (ties by raster position) and emits rank and (rank+1)/(n+1).
// ---------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | start && !busy      | in_sample_value, in_is_final
//  result   | out_valid (strobe)  | out_rank_index, out_threshold_fraction,
//           |                     | out_run_end, out_overflowed
//
//  A two-entry queue parts the front end from the ranking engine; busy rises
//  only when that queue is full.
//  Ranking a value pops it from the queue, then reads the value and rank RAMs
//  one entry a cycle over the n values already stored. A dropped value is
//  popped without a scan.
//  Each result waits on the bit-serial divider (16 steps) and the rank RAM
//  read ahead of it.
//  Reset is synchronous and active low; no clearing pass is needed, as only
//  entries written in the current run are ever read.
//  Results cannot be held off: each strobe is a completed transfer.
// ---------------------------------------------------------------------------
module kernel_rank_normalizer_unit
  import krn_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [VAL_W-1:0] in_sample_value,
  input  wire logic                    in_is_final,
  output logic                         out_valid,
  output logic [RANK_W-1:0]            out_rank_index,
  output logic [FRAC_W-1:0]            out_threshold_fraction,
  output logic                         out_run_end,
  output logic                         out_overflowed
);

  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  // Front end: accept, classify against capacity, queue
  krn_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_value (in_sample_value),
    .in_is_final     (in_is_final),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Back end: rank each value, then emit the run in raster order
  krn_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res)
  );

  // Unpack the result record onto its own ports
  assign out_rank_index         = res.rank;
  assign out_threshold_fraction = res.frac;
  assign out_run_end            = res.run_end;
  assign out_overflowed         = res.ovf;

endmodule : kernel_rank_normalizer_unit
`default_nettype wire

// ===== rtl/krn_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// krn_checker
// Port-level checks of the kernel rank normaliser, bound to the top level.
// ---------------------------------------------------------------------------
module krn_checker
  import krn_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [FRAC_W-1:0] out_threshold_fraction
);

  // Reset leaves no strobe and an empty queue behind
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("strobe or busy after reset");

  // Each result needs a full division, so strobes never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes on consecutive cycles");

  // At most 64 entries, so the fraction is never zero
  a_frac_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_threshold_fraction != '0)
    else $error("zero threshold fraction");

endmodule : krn_checker

bind kernel_rank_normalizer_unit krn_checker u_krn_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .busy                   (busy),
  .out_valid              (out_valid),
  .out_threshold_fraction (out_threshold_fraction)
);
`default_nettype wire

// ===== bench/rank_normalizer_monitor.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rank_normalizer_monitor
// Watches both channels of the kernel rank normaliser. It ranks every
// transferred value as the block should, queues the results of each run and
// compares each result strobe with the oldest queued result, field by field.
// ---------------------------------------------------------------------------
module rank_normalizer_monitor
  import krn_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [VAL_W-1:0] in_sample_value,
  input  logic                    in_is_final,
  input  logic                    out_valid,
  input  logic [RANK_W-1:0]       out_rank_index,
  input  logic [FRAC_W-1:0]       out_threshold_fraction,
  input  logic                    out_run_end,
  input  logic                    out_overflowed,
  output int                      mismatch_count,
  output int                      results_due
);

  logic signed [VAL_W-1:0] kept_value [MAX_ENTRIES];
  logic [RANK_W-1:0]       kept_rank  [MAX_ENTRIES];
  int                      kept_count;
  bit                      dropped_any;
  result_t                 due_results [$];

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    kept_count     = 0;
    dropped_any    = 1'b0;
    foreach (kept_rank[i]) kept_rank[i] = '0;
  end

  // Rank the new value among the kept ones; every larger kept value moves up one
  function automatic void rank_value(input logic signed [VAL_W-1:0] v);
    int place;
    place = 0;
    for (int i = 0; i < kept_count; i++) begin
      if (kept_value[i] <= v) place++;
      else kept_rank[i] = kept_rank[i] + 1'b1;
    end
    kept_value[kept_count] = v;
    kept_rank[kept_count]  = RANK_W'(place);
    kept_count++;
  endfunction

  // Queue one result per kept position in raster order, then start afresh
  function automatic void close_run();
    result_t     r;
    logic [31:0] scaled;
    for (int k = 0; k < kept_count; k++) begin
      scaled    = ((32'(kept_rank[k]) + 32'd1) << FRAC_W) / (32'(kept_count) + 32'd1);
      r.rank    = kept_rank[k];
      r.frac    = scaled[FRAC_W-1:0];
      r.run_end = (k == kept_count - 1);
      r.ovf     = dropped_any;
      due_results.push_back(r);
    end
    kept_count  = 0;
    dropped_any = 1'b0;
    foreach (kept_rank[i]) kept_rank[i] = '0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      kept_count  = 0;
      dropped_any = 1'b0;
      foreach (kept_rank[i]) kept_rank[i] = '0;
      due_results.delete();
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: rank %0d, fraction %0d", out_rank_index,
                 out_threshold_fraction);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("out_rank_index", 32'(want.rank), 32'(out_rank_index));
          check_field("out_threshold_fraction", 32'(want.frac),
                      32'(out_threshold_fraction));
          check_field("out_run_end", 32'(want.run_end), 32'(out_run_end));
          check_field("out_overflowed", 32'(want.ovf), 32'(out_overflowed));
        end
      end
      if (start && !busy) begin
        if (kept_count < MAX_ENTRIES) rank_value(in_sample_value);
        else dropped_any = 1'b1;
        if (in_is_final) close_run();
      end
    end
    results_due = due_results.size();
  end

endmodule : rank_normalizer_monitor

// ===== bench/kernel_rank_normalizer_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kernel_rank_normalizer_unit_test
// Drives runs of kernel values into the rank normaliser: a handful of fixed
// runs for extremes, ties and ordering, runs that fill and overrun the store,
// then runs of random length and content with random idle gaps. A monitor
// beside the block predicts every result and counts mismatches.
// ---------------------------------------------------------------------------
module kernel_rank_normalizer_unit_test;
  import krn_pkg::*;

  localparam int MAX_ENTRIES    = 64;
  localparam int CLK_HALF       = 6;        // 12 ns period
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 30;
  localparam int TAIL_CYCLES    = 200;      // several result times of the divider
  localparam int TIMEOUT_CYCLES = 400_000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [VAL_W-1:0] in_sample_value;
  logic                    in_is_final;
  logic                    out_valid;
  logic [RANK_W-1:0]       out_rank_index;
  logic [FRAC_W-1:0]       out_threshold_fraction;
  logic                    out_run_end;
  logic                    out_overflowed;
  int                      mismatch_count;
  int                      results_due;

  // Idle gaps between transfers are only inserted while this is set
  bit                      gaps_on;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  kernel_rank_normalizer_unit #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_sample_value       (in_sample_value),
    .in_is_final           (in_is_final),
    .out_valid             (out_valid),
    .out_rank_index        (out_rank_index),
    .out_threshold_fraction(out_threshold_fraction),
    .out_run_end           (out_run_end),
    .out_overflowed        (out_overflowed)
  );

  rank_normalizer_monitor #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_monitor (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_sample_value       (in_sample_value),
    .in_is_final           (in_is_final),
    .out_valid             (out_valid),
    .out_rank_index        (out_rank_index),
    .out_threshold_fraction(out_threshold_fraction),
    .out_run_end           (out_run_end),
    .out_overflowed        (out_overflowed),
    .mismatch_count        (mismatch_count),
    .results_due           (results_due)
  );

  // Mix of extremes, a narrow band around zero (plenty of ties) and full range
  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return {1'b1, {(VAL_W-1){1'b0}}};
    if (sel == 1) return {1'b0, {(VAL_W-1){1'b1}}};
    if (sel <= 4) return VAL_W'($urandom_range(0, 4)) - VAL_W'(2);
    return $urandom;
  endfunction

  // Hold one item on the port until it transfers. The caller's next item may
  // follow on the very next edge; with gaps enabled, sometimes drop start for
  // a while (mostly briefly, now and then for long) and scribble junk on the
  // payload so that an unqualified capture would show up.
  task automatic send_value(input logic signed [VAL_W-1:0] v, input logic fin);
    start           <= 1'b1;
    in_sample_value <= v;
    in_is_final     <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start           <= 1'b0;
      in_sample_value <= $urandom;
      in_is_final     <= 1'($urandom_range(0, 1));
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  // One whole run of random values, the last one flagged as final
  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
  endtask

  // Stop sending and hold off until every queued result has been seen. It
  // first waits for a clock edge so the monitor has counted the last transfer.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int run_len;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_sample_value <= '0;
    in_is_final     <= 1'b0;
    gaps_on          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A run of one value: rank 0, fraction one half
    send_value(32'sh0001_0000, 1'b1);

    // Both extremes, zero and minus one, each twice: ties must resolve by raster order
    send_value({1'b1, {(VAL_W-1){1'b0}}}, 1'b0);
    send_value({1'b0, {(VAL_W-1){1'b1}}}, 1'b0);
    send_value('0, 1'b0);
    send_value('1, 1'b0);
    send_value({1'b0, {(VAL_W-1){1'b1}}}, 1'b0);
    send_value({1'b1, {(VAL_W-1){1'b0}}}, 1'b0);
    send_value('0, 1'b0);
    send_value('1, 1'b1);

    // Strictly descending: each new value pushes every kept rank up
    for (int i = 0; i < 6; i++) send_value(VAL_W'(600 - 100 * i), i == 5);

    // All equal: ranks follow position exactly
    for (int i = 0; i < 4; i++) send_value(32'sd42, i == 3);

    // Hold the sender until the fixed runs have fully drained
    wait_drained();

    // Capacity runs: exactly full, then a few over (the final value is itself
    // dropped but still closes the run)
    gaps_on = 1'b1;
    send_run(MAX_ENTRIES);
    send_run(MAX_ENTRIES + $urandom_range(2, 4));

    // Random runs: mostly short, the odd long one; gaps switched per run so
    // that some runs stream back to back
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      run_len = ($urandom_range(0, 14) == 0) ? $urandom_range(11, MAX_ENTRIES)
                                             : $urandom_range(1, 10);
      send_run(run_len);
      sent += run_len;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("== FAIL ==");
    $finish;
  end

endmodule : kernel_rank_normalizer_unit_test

// ===== files.f =====
rtl/krn_pkg.sv
rtl/krn_ram.sv
rtl/krn_front.sv
rtl/krn_div.sv
rtl/krn_back.sv
rtl/kernel_rank_normalizer_unit.sv
rtl/krn_checker.sv
bench/rank_normalizer_monitor.sv
bench/kernel_rank_normalizer_unit_test.sv
